### hdl/tvsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsm_pkg
// Shared types and constants of the two-voice sample mixer.
// ----------------------------------------------------------------------------
package tvsm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int MIX_W      = 17;
    localparam int POS_W      = 25;
    localparam int FRAC_W     = 8;
    localparam int IDX_W      = POS_W - FRAC_W;
    localparam int RATE_W     = 16;
    localparam int LEN_W      = 17;
    localparam int ADDR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

    // Input item kinds
    typedef enum logic [1:0]
    {
        KIND_TICK   = 2'd0,
        KIND_SND_WR = 2'd1,
        KIND_AMB_WR = 2'd2,
        KIND_START  = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_SOUND_RATE   = 3'd0,
        CFG_AMB_RATE     = 3'd1,
        CFG_SOUND_LENGTH = 3'd2,
        CFG_AMB_LENGTH   = 3'd3,
        CFG_AMB_ENABLE   = 3'd4
    } cfg_idx_t;

    // Per-tick control passed from playhead stage to mix stage
    typedef struct packed
    {
        logic valid;     // a tick was accepted this cycle
        logic amb_hit;   // ambience voice contributes its sample
        logic snd_hit;   // one-shot voice contributes its sample
        logic playing;   // one-shot still active after end check
    } tick_t;

endpackage

### hdl/two_voice_sample_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_voice_sample_mixer_unit
// Two-voice stereo sample player: one-shot sound plus looping ambience.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle of any kind (tick, sound write, ambience
// write, start) while s_tready is high; a stalled output can drop it. A tick
// gives one mixed stereo result, through the registered read of each sample
// RAM and then the output register; other kinds give none. Each RAM has one
// write and one read port, so a write and a tick never compete. Sample RAMs
// are not cleared after reset and need no clearing pass: a frame read before
// it is written returns whatever the RAM holds. Configuration is taken at any
// cycle through cfg_we, cfg_index, cfg_data.
// ----------------------------------------------------------------------------
module two_voice_sample_mixer_unit #(
    parameter int SOUND_FRAMES    = 65536,
    parameter int AMBIENCE_FRAMES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address[15:0], left_in[31:16], right_in[47:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // left_out[16:0], right_out[33:17],
                                   // sound_playing[34], zero[39:35]
);

    localparam int SAW = $clog2(SOUND_FRAMES);
    localparam int AAW = $clog2(AMBIENCE_FRAMES);
    localparam int SWW = (SAW > tvsm_pkg::ADDR_W) ? SAW : tvsm_pkg::ADDR_W;
    localparam int AWW = (AAW > tvsm_pkg::ADDR_W) ? AAW : tvsm_pkg::ADDR_W;

    logic                          accept;
    tvsm_pkg::kind_t               kind;
    logic [tvsm_pkg::ADDR_W-1:0]   address;
    logic [tvsm_pkg::FRAME_W-1:0]  frame;
    logic [SWW-1:0]                snd_wr_ext;
    logic [AWW-1:0]                amb_wr_ext;
    logic                          snd_wr_en;
    logic                          amb_wr_en;
    logic                          snd_rd_en;
    logic [SAW-1:0]                snd_rd_addr;
    logic                          amb_rd_en;
    logic [AAW-1:0]                amb_rd_addr;
    logic [tvsm_pkg::FRAME_W-1:0]  snd_rd_data;
    logic [tvsm_pkg::FRAME_W-1:0]  amb_rd_data;
    tvsm_pkg::tick_t               tick;
    logic [tvsm_pkg::MIX_W-1:0]    left_out;
    logic [tvsm_pkg::MIX_W-1:0]    right_out;
    logic                          sound_playing;

    // Request decode
    assign accept  = s_tvalid && s_tready;
    assign kind    = tvsm_pkg::kind_t'(s_tuser);
    assign address = s_tdata[15:0];
    assign frame   = s_tdata[47:16];   // left low, right high

    // Store writes; addresses beyond the depth are dropped
    assign snd_wr_ext = SWW'(address);
    assign amb_wr_ext = AWW'(address);
    assign snd_wr_en  = accept && (kind == tvsm_pkg::KIND_SND_WR)
                        && (32'(address) < 32'(SOUND_FRAMES));
    assign amb_wr_en  = accept && (kind == tvsm_pkg::KIND_AMB_WR)
                        && (32'(address) < 32'(AMBIENCE_FRAMES));

    tvsm_playhead #(
        .SOUND_FRAMES    (SOUND_FRAMES),
        .AMBIENCE_FRAMES (AMBIENCE_FRAMES)
    ) u_playhead (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .kind        (kind),
        .snd_rd_en   (snd_rd_en),
        .snd_rd_addr (snd_rd_addr),
        .amb_rd_en   (amb_rd_en),
        .amb_rd_addr (amb_rd_addr),
        .tick        (tick)
    );

    tvsm_store #(
        .DEPTH (SOUND_FRAMES)
    ) u_snd_store (
        .clk     (clk),
        .wr_en   (snd_wr_en),
        .wr_addr (snd_wr_ext[SAW-1:0]),
        .wr_data (frame),
        .rd_en   (snd_rd_en),
        .rd_addr (snd_rd_addr),
        .rd_data (snd_rd_data)
    );

    tvsm_store #(
        .DEPTH (AMBIENCE_FRAMES)
    ) u_amb_store (
        .clk     (clk),
        .wr_en   (amb_wr_en),
        .wr_addr (amb_wr_ext[AAW-1:0]),
        .wr_data (frame),
        .rd_en   (amb_rd_en),
        .rd_addr (amb_rd_addr),
        .rd_data (amb_rd_data)
    );

    tvsm_mix u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .snd_rd_data   (snd_rd_data),
        .amb_rd_data   (amb_rd_data),
        .in_ready      (s_tready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .left_out      (left_out),
        .right_out     (right_out),
        .sound_playing (sound_playing)
    );

    assign m_tdata = {5'd0, sound_playing, right_out, left_out};

endmodule

### hdl/tvsm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsm_store
// Single-port-pair sample RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tvsm_store #(
    parameter int DEPTH = 65536
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [tvsm_pkg::FRAME_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [tvsm_pkg::FRAME_W-1:0] rd_data
);

    logic [tvsm_pkg::FRAME_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/tvsm_playhead.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsm_playhead
// Configuration registers, both playheads and the one-shot arm flag.
// Does the end checks on a tick and issues the store reads.
// ----------------------------------------------------------------------------
module tvsm_playhead #(
    parameter int SOUND_FRAMES    = 65536,
    parameter int AMBIENCE_FRAMES = 65536
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tvsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tvsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    input  tvsm_pkg::kind_t                    kind,
    output logic                               snd_rd_en,
    output logic [$clog2(SOUND_FRAMES)-1:0]    snd_rd_addr,
    output logic                               amb_rd_en,
    output logic [$clog2(AMBIENCE_FRAMES)-1:0] amb_rd_addr,
    output tvsm_pkg::tick_t                    tick
);

    localparam int SAW = $clog2(SOUND_FRAMES);
    localparam int AAW = $clog2(AMBIENCE_FRAMES);
    localparam int SXW = (SAW > tvsm_pkg::IDX_W) ? SAW : tvsm_pkg::IDX_W;
    localparam int AXW = (AAW > tvsm_pkg::IDX_W) ? AAW : tvsm_pkg::IDX_W;

    logic [tvsm_pkg::RATE_W-1:0] snd_rate_reg;
    logic [tvsm_pkg::RATE_W-1:0] amb_rate_reg;
    logic [tvsm_pkg::LEN_W-1:0]  snd_len_reg;
    logic [tvsm_pkg::LEN_W-1:0]  amb_len_reg;
    logic                        amb_en_reg;

    logic [tvsm_pkg::POS_W-1:0]  snd_pos_reg;
    logic [tvsm_pkg::POS_W-1:0]  snd_pos_next;
    logic [tvsm_pkg::POS_W-1:0]  amb_pos_reg;
    logic [tvsm_pkg::POS_W-1:0]  amb_pos_next;
    logic                        snd_active_reg;
    logic                        snd_active_next;

    logic                        is_tick;
    logic                        is_start;
    logic [tvsm_pkg::POS_W-1:0]  amb_base;
    logic [tvsm_pkg::IDX_W-1:0]  amb_idx;
    logic [tvsm_pkg::IDX_W-1:0]  snd_idx;
    logic                        amb_run;
    logic                        snd_run;
    logic [SXW-1:0]              snd_idx_ext;
    logic [AXW-1:0]              amb_idx_ext;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snd_rate_reg <= tvsm_pkg::RATE_RESET;
            amb_rate_reg <= tvsm_pkg::RATE_RESET;
            snd_len_reg  <= '0;
            amb_len_reg  <= '0;
            amb_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tvsm_pkg::CFG_SOUND_RATE:
                    snd_rate_reg <= cfg_data[tvsm_pkg::RATE_W-1:0];
                tvsm_pkg::CFG_AMB_RATE:
                    amb_rate_reg <= cfg_data[tvsm_pkg::RATE_W-1:0];
                tvsm_pkg::CFG_SOUND_LENGTH:
                    snd_len_reg  <= cfg_data[tvsm_pkg::LEN_W-1:0];
                tvsm_pkg::CFG_AMB_LENGTH:
                    amb_len_reg  <= cfg_data[tvsm_pkg::LEN_W-1:0];
                tvsm_pkg::CFG_AMB_ENABLE:
                    amb_en_reg   <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    assign is_tick  = accept && (kind == tvsm_pkg::KIND_TICK);
    assign is_start = accept && (kind == tvsm_pkg::KIND_START);

    // Ambience: wrap at length, then play and advance if inside the loop
    always_comb
    begin
        amb_base     = (amb_pos_reg[tvsm_pkg::POS_W-1:tvsm_pkg::FRAC_W] >= amb_len_reg)
                       ? '0 : amb_pos_reg;
        amb_idx      = amb_base[tvsm_pkg::POS_W-1:tvsm_pkg::FRAC_W];
        amb_run      = amb_en_reg && (amb_idx < amb_len_reg);
        amb_pos_next = amb_pos_reg;
        if (is_tick && amb_en_reg)
        begin
            amb_pos_next = amb_run
                ? amb_base + tvsm_pkg::POS_W'(amb_rate_reg)
                : amb_base;
        end
    end

    // One-shot: stop at length, otherwise play and advance
    always_comb
    begin
        snd_idx         = snd_pos_reg[tvsm_pkg::POS_W-1:tvsm_pkg::FRAC_W];
        snd_run         = snd_active_reg && (snd_idx < snd_len_reg);
        snd_pos_next    = snd_pos_reg;
        snd_active_next = snd_active_reg;
        if (is_start)
        begin
            snd_pos_next    = '0;
            snd_active_next = 1'b1;
        end
        else if (is_tick)
        begin
            snd_active_next = snd_run;
            if (snd_run)
            begin
                snd_pos_next = snd_pos_reg + tvsm_pkg::POS_W'(snd_rate_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snd_pos_reg    <= '0;
            amb_pos_reg    <= '0;
            snd_active_reg <= 1'b0;
        end
        else
        begin
            snd_pos_reg    <= snd_pos_next;
            amb_pos_reg    <= amb_pos_next;
            snd_active_reg <= snd_active_next;
        end
    end

    // Store reads; a frame beyond the store depth plays silence
    assign snd_idx_ext = SXW'(snd_idx);
    assign amb_idx_ext = AXW'(amb_idx);
    assign snd_rd_addr = snd_idx_ext[SAW-1:0];
    assign amb_rd_addr = amb_idx_ext[AAW-1:0];
    assign snd_rd_en   = is_tick && snd_run && (32'(snd_idx) < 32'(SOUND_FRAMES));
    assign amb_rd_en   = is_tick && amb_run && (32'(amb_idx) < 32'(AMBIENCE_FRAMES));

    assign tick.valid   = is_tick;
    assign tick.amb_hit = amb_rd_en;
    assign tick.snd_hit = snd_rd_en;
    assign tick.playing = snd_run;

    // A start rewinds and arms the one-shot
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        is_start |=> (snd_active_reg && (snd_pos_reg == '0)))
        else $error("start did not rewind and arm the one-shot");

    // Disabled ambience holds its playhead
    a_amb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && !amb_en_reg) |=> $stable(amb_pos_reg))
        else $error("disabled ambience playhead moved");

    // Playheads only move on accepted ticks or starts
    a_pos_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!is_tick && !is_start) |=> ($stable(snd_pos_reg) && $stable(amb_pos_reg)
                                     && $stable(snd_active_reg)))
        else $error("playhead state changed without a tick or start");

endmodule

### hdl/tvsm_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsm_mix
// Read-data stage and output register: sums the active voices and holds
// the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tvsm_mix (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tvsm_pkg::tick_t              tick,
    input  logic [tvsm_pkg::FRAME_W-1:0] snd_rd_data,
    input  logic [tvsm_pkg::FRAME_W-1:0] amb_rd_data,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tvsm_pkg::MIX_W-1:0]   left_out,
    output logic [tvsm_pkg::MIX_W-1:0]   right_out,
    output logic                         sound_playing
);

    localparam int SW = tvsm_pkg::SAMPLE_W;

    tvsm_pkg::tick_t               s1_reg;
    logic                          s1_valid_reg;
    logic                          out_valid_reg;
    logic                          advance;
    logic [tvsm_pkg::MIX_W-1:0]    snd_l;
    logic [tvsm_pkg::MIX_W-1:0]    snd_r;
    logic [tvsm_pkg::MIX_W-1:0]    amb_l;
    logic [tvsm_pkg::MIX_W-1:0]    amb_r;
    logic [tvsm_pkg::MIX_W-1:0]    left_reg;
    logic [tvsm_pkg::MIX_W-1:0]    right_reg;
    logic                          playing_reg;

    // Stage 1 moves on when the output register is free or being emptied
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.valid)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid)
        begin
            s1_reg <= tick;
        end
    end

    // Sign-extended voice samples, silence for idle voices
    always_comb
    begin
        snd_l = s1_reg.snd_hit ? {snd_rd_data[SW-1], snd_rd_data[SW-1:0]} : '0;
        snd_r = s1_reg.snd_hit ? {snd_rd_data[2*SW-1], snd_rd_data[2*SW-1:SW]} : '0;
        amb_l = s1_reg.amb_hit ? {amb_rd_data[SW-1], amb_rd_data[SW-1:0]} : '0;
        amb_r = s1_reg.amb_hit ? {amb_rd_data[2*SW-1], amb_rd_data[2*SW-1:SW]} : '0;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_reg    <= snd_l + amb_l;
            right_reg   <= snd_r + amb_r;
            playing_reg <= s1_reg.playing;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_out      = left_reg;
    assign right_out     = right_reg;
    assign sound_playing = playing_reg;

endmodule

### test/tvsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvsm_checker
// Predicts and checks the mixed output of the two-voice sample mixer.
// ----------------------------------------------------------------------------
// Sits beside the mixer and watches its configuration port and both streams.
// Accepted requests and configuration writes update a private copy of the
// sample stores, the playheads and the registers; every tick owes one mixed
// frame. Each accepted result is compared field by field with the oldest
// owed frame. The counts of failures and of frames still owed go to the top.
// ----------------------------------------------------------------------------
module tvsm_checker #(
    parameter int SOUND_FRAMES    = 65536,
    parameter int AMBIENCE_FRAMES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // address[15:0], left_in[31:16], right_in[47:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // left_out[16:0], right_out[33:17], sound_playing[34]
    output int          mix_fails,
    output int          mix_pending
);

    localparam int PW = tvsm_pkg::POS_W;
    localparam int FW = tvsm_pkg::FRAC_W;

    typedef struct packed
    {
        logic signed [tvsm_pkg::MIX_W-1:0] left;
        logic signed [tvsm_pkg::MIX_W-1:0] right;
        logic                              playing;
    } mix_t;

    // private copy of the stores (left low, right high)
    logic [31:0] snd_mem [SOUND_FRAMES];
    logic [31:0] amb_mem [AMBIENCE_FRAMES];

    // playheads, Q17.8
    logic [PW-1:0] snd_pos;
    logic [PW-1:0] amb_pos;
    logic          snd_on;

    // register copies
    logic [15:0]   snd_step;
    logic [15:0]   amb_step;
    logic [16:0]   snd_len;
    logic [16:0]   amb_len;
    logic          amb_on;

    mix_t owed_mix [$];
    int   errs = 0;

    assign mix_fails = errs;

    // One frame tick: wrap/stop checks, mix of the live voices, then advance
    function automatic mix_t mix_next_frame();
        logic [tvsm_pkg::IDX_W-1:0] idx;
        mix_t res;
        res = '0;
        if (amb_on)
        begin
            if (amb_pos[PW-1:FW] >= amb_len)
                amb_pos = '0;
            idx = amb_pos[PW-1:FW];
            if (idx < amb_len)
            begin
                if (idx < AMBIENCE_FRAMES)
                begin
                    res.left  = res.left  + $signed(amb_mem[idx][15:0]);
                    res.right = res.right + $signed(amb_mem[idx][31:16]);
                end
                amb_pos = amb_pos + amb_step;
            end
        end
        if (snd_on && snd_pos[PW-1:FW] >= snd_len)
            snd_on = 1'b0;
        if (snd_on)
        begin
            idx = snd_pos[PW-1:FW];
            if (idx < SOUND_FRAMES)
            begin
                res.left  = res.left  + $signed(snd_mem[idx][15:0]);
                res.right = res.right + $signed(snd_mem[idx][31:16]);
            end
            snd_pos = snd_pos + snd_step;
        end
        res.playing = snd_on;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mix_t got;
        mix_t want;
        if (!rst_n)
        begin
            snd_pos  = '0;
            amb_pos  = '0;
            snd_on   = 1'b0;
            snd_step = tvsm_pkg::RATE_RESET;
            amb_step = tvsm_pkg::RATE_RESET;
            snd_len  = '0;
            amb_len  = '0;
            amb_on   = 1'b0;
            owed_mix.delete();
            mix_pending <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    tvsm_pkg::CFG_SOUND_RATE:   snd_step = cfg_data[15:0];
                    tvsm_pkg::CFG_AMB_RATE:     amb_step = cfg_data[15:0];
                    tvsm_pkg::CFG_SOUND_LENGTH: snd_len  = cfg_data;
                    tvsm_pkg::CFG_AMB_LENGTH:   amb_len  = cfg_data;
                    tvsm_pkg::CFG_AMB_ENABLE:   amb_on   = cfg_data[0];
                    default: ;
                endcase
            end

            // accepted request
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    tvsm_pkg::KIND_SND_WR:
                        if (s_tdata[15:0] < SOUND_FRAMES)
                            snd_mem[s_tdata[15:0]] = s_tdata[47:16];
                    tvsm_pkg::KIND_AMB_WR:
                        if (s_tdata[15:0] < AMBIENCE_FRAMES)
                            amb_mem[s_tdata[15:0]] = s_tdata[47:16];
                    tvsm_pkg::KIND_START:
                    begin
                        snd_pos = '0;
                        snd_on  = 1'b1;
                    end
                    default:
                        owed_mix.push_back(mix_next_frame());
                endcase
            end

            // accepted result against the oldest owed frame
            if (m_tvalid && m_tready)
            begin
                got.left    = m_tdata[16:0];
                got.right   = m_tdata[33:17];
                got.playing = m_tdata[34];
                if (owed_mix.size() == 0)
                begin
                    if (errs < 10)
                        $display("%0t: unexpected result left %0d right %0d playing %0b",
                                 $realtime, got.left, got.right, got.playing);
                    errs++;
                end
                else
                begin
                    want = owed_mix.pop_front();
                    if (got.left != want.left || got.right != want.right
                        || got.playing != want.playing)
                    begin
                        if (errs < 10)
                            $display("%0t: mix mismatch exp L %0d R %0d P %0b, got L %0d R %0d P %0b",
                                     $realtime, want.left, want.right, want.playing,
                                     got.left, got.right, got.playing);
                        errs++;
                    end
                end
            end
            mix_pending <= owed_mix.size();
        end
    end

endmodule

### test/tb_two_voice_sample_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_voice_sample_mixer_unit
// Stimulus and verdict for the two-voice sample mixer.
// ----------------------------------------------------------------------------
// After a few ticks on the reset settings, the first FILL_FRAMES frames of
// both sample stores are written. Every random length, and every frame
// played under the longest lengths, stays inside that region, so no tick
// can ever play an unwritten frame. A short directed run then
// covers full-scale sums, the one-shot end, the ambience wrap, restarts,
// zero and maximum rates, an empty ambience and the longest lengths. Random
// phases follow, each with fresh settings, mostly a start, then mixed ticks,
// restarts and store writes. Both streams idle in random bursts, except in
// the final phases. Checking is done by tvsm_checker.
// ----------------------------------------------------------------------------
module tb_two_voice_sample_mixer_unit;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int FILL_FRAMES     = 256;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int QUIET_TAIL      = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // address[15:0], left_in[31:16], right_in[47:32]
    logic [1:0]  s_tuser   = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [39:0] m_tdata;          // left_out[16:0], right_out[33:17], sound_playing[34]

    int mix_fails;
    int mix_pending;

    // idling percentages for the sender and the receiver
    int idle_pct  = 0;
    int stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    two_voice_sample_mixer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tvsm_checker mix_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mix_fails   (mix_fails),
        .mix_pending (mix_pending)
    );

    // One request; may open with an idle burst
    task automatic send_request(tvsm_pkg::kind_t k, logic [15:0] addr, logic [15:0] left,
                                logic [15:0] right);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {right, left, addr};
        do @(posedge clk); while (!s_tready);
    endtask

    // Writes all five registers back to back; block must be idle
    task automatic load_settings(logic [15:0] snd_rate, logic [15:0] amb_rate,
                                 logic [16:0] snd_len, logic [16:0] amb_len,
                                 logic amb_en);
        cfg_we    <= 1'b1;
        cfg_index <= tvsm_pkg::CFG_SOUND_RATE;
        cfg_data  <= {1'b0, snd_rate};
        @(posedge clk);
        cfg_index <= tvsm_pkg::CFG_AMB_RATE;
        cfg_data  <= {1'b0, amb_rate};
        @(posedge clk);
        cfg_index <= tvsm_pkg::CFG_SOUND_LENGTH;
        cfg_data  <= snd_len;
        @(posedge clk);
        cfg_index <= tvsm_pkg::CFG_AMB_LENGTH;
        cfg_data  <= amb_len;
        @(posedge clk);
        cfg_index <= tvsm_pkg::CFG_AMB_ENABLE;
        cfg_data  <= {16'd0, amb_en};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Wait for every owed frame, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (mix_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd256;
            3:       return 16'hFFFF;
            4:       return 16'd255;
            7:       return 16'($urandom);
            default: return 16'($urandom_range(64, 1024));
        endcase
    endfunction

    // Lengths stay inside the written region of the stores
    function automatic logic [16:0] pick_len();
        case ($urandom_range(7))
            0:       return 17'd0;
            1:       return 17'd1;
            2:       return 17'(FILL_FRAMES);
            3:       return 17'd2;
            6:       return 17'($urandom_range(1, FILL_FRAMES));
            7:       return 17'($urandom_range(65, FILL_FRAMES));
            default: return 17'($urandom_range(2, 64));
        endcase
    endfunction

    function automatic int pick_pace();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // Receiver: random stall bursts
    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int              served;
        int              sel;
        logic [15:0]     a;
        logic [15:0]     l;
        logic [15:0]     r;
        tvsm_pkg::kind_t k;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: both voices silent, a start on zero length stops at once
        send_request(tvsm_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(tvsm_pkg::KIND_START, 16'd0, 16'd0, 16'd0);
        send_request(tvsm_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0);

        // fill the low frames of both stores; frames 0 and 1 carry full-scale extremes
        idle_pct = 2;
        for (int i = 0; i < FILL_FRAMES; i++)
        begin
            l = 16'($urandom);
            r = 16'($urandom);
            if (i == 0)
            begin
                l = 16'h8000;
                r = 16'h7FFF;
            end
            else if (i == 1)
            begin
                l = 16'h7FFF;
                r = 16'h8000;
            end
            send_request(tvsm_pkg::KIND_SND_WR, 16'(i), l, r);
            if (i > 1)
            begin
                l = 16'($urandom);
                r = 16'($urandom);
            end
            send_request(tvsm_pkg::KIND_AMB_WR, 16'(i), l, r);
        end
        settle();

        // short sound over a three-frame loop: end of sound, wrap, restarts
        idle_pct  = 20;
        stall_pct = 20;
        load_settings(16'd256, 16'd256, 17'd4, 17'd3, 1'b1);
        send_request(tvsm_pkg::KIND_START, 16'd0, 16'd0, 16'd0);
        repeat (5) send_request(tvsm_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0);
        send_request(tvsm_pkg::KIND_START, 16'd0, 16'd0, 16'd0);
        send_request(tvsm_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0);
        send_request(tvsm_pkg::KIND_START, 16'd0, 16'd0, 16'd0);
        send_request(tvsm_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0);
        settle();

        // zero rates and an empty ambience
        load_settings(16'd0, 16'd0, 17'd65536, 17'd0, 1'b1);
        send_request(tvsm_pkg::KIND_START, 16'd0, 16'd0, 16'd0);
        repeat (2) send_request(tvsm_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0);
        settle();

        // top rates and longest lengths, ambience off then on; two ticks reach frame 255
        load_settings(16'hFFFF, 16'hFFFF, 17'd65536, 17'd65536, 1'b0);
        send_request(tvsm_pkg::KIND_START, 16'd0, 16'd0, 16'd0);
        repeat (2) send_request(tvsm_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0);
        settle();
        load_settings(16'hFFFF, 16'hFFFF, 17'd65536, 17'd65536, 1'b1);
        send_request(tvsm_pkg::KIND_START, 16'd0, 16'd0, 16'd0);
        repeat (2) send_request(tvsm_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0);
        settle();

        // random phases, each with fresh settings
        served = 0;
        while (served < RANDOM_REQUESTS)
        begin
            load_settings(pick_rate(), pick_rate(), pick_len(), pick_len(),
                          $urandom_range(3) != 0);
            if (served >= RANDOM_REQUESTS - QUIET_TAIL)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct  = pick_pace();
                stall_pct = pick_pace();
            end
            if ($urandom_range(9) < 7)
                send_request(tvsm_pkg::KIND_START, 16'($urandom), 16'($urandom),
                             16'($urandom));
            repeat ($urandom_range(20, 80))
            begin
                sel = $urandom_range(99);
                // keep half the writes near the playheads of short sounds
                a = ($urandom_range(1) != 0) ? 16'($urandom_range(0, 63)) : 16'($urandom);
                if (sel < 6)
                    k = tvsm_pkg::KIND_START;
                else if (sel < 18)
                    k = tvsm_pkg::KIND_SND_WR;
                else if (sel < 30)
                    k = tvsm_pkg::KIND_AMB_WR;
                else
                    k = tvsm_pkg::KIND_TICK;
                send_request(k, a, 16'($urandom), 16'($urandom));
                served++;
            end
            settle();
        end

        if (mix_fails == 0 && mix_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/tvsm_pkg.sv
hdl/tvsm_store.sv
hdl/tvsm_playhead.sv
hdl/tvsm_mix.sv
hdl/two_voice_sample_mixer_unit.sv
test/tvsm_checker.sv
test/tb_two_voice_sample_mixer_unit.sv
